@@ hdl/rc4x_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4x_pkg
// shared types and constants of the rc4 / xor stream cipher unit
// ----------------------------------------------------------------------------
package rc4x_pkg;

   typedef logic [7:0] byte_type;

   // status of the iterative remainder unit
   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

   // configuration register indexes
   localparam logic [1:0] CSR_CIPHER_MODE  = 2'd0;
   localparam logic [1:0] CSR_KEY_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_START_OFFSET = 2'd2;

   localparam byte_type BYTE_LAST = 8'hFF;

endpackage

@@ hdl/rc4x_mod_unit.sv @@
// ----------------------------------------------------------------------------
// rc4x_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module rc4x_mod_unit import rc4x_pkg::*; #(
   parameter int OB = 32,
   parameter int LW = 9
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [OB-1:0]  dividend,
   input  logic [LW-1:0]  divisor,
   output mod_status_type status,
   output logic [LW-1:0]  remainder
);

   localparam int CW = $clog2(OB + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [OB-1:0] quo_ff, quo_in;
   logic [LW-1:0] dsr_ff, dsr_in;
   logic [LW-1:0] rem_ff, rem_in;
   logic [LW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, quo_ff[OB-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(OB);
         quo_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so one subtract per bit
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = LW'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = LW'(trial);
         end
         quo_in = {quo_ff[OB-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

@@ hdl/rc4_or_xor_stream_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// rc4_or_xor_stream_cipher_unit
// byte stream cipher: repeating-key xor or rc4 keystream
// ----------------------------------------------------------------------------
// One word is taken at a time. A key word (func 0) is written into the key
// store, bytes beyond its depth dropped, and gives no result. A data word
// (func 1) gives one result word. In xor mode a data word steps through
// accept, key store read and result; the first data word of a message also
// runs a bit-serial remainder of start_offset by the key length. In rc4 mode
// a data word steps through S_P1 to S_P6 around the permutation memory
// (three reads and two writes per keystream byte). The first data word of an
// rc4 message first loads the identity permutation, runs the key schedule
// over all 256 entries and discards start_offset keystream bytes. The input
// is not ready while a result word still waits in the output register. Mode,
// key length and offset are taken at the first data word of a message;
// last_in on a data word ends it.
// ----------------------------------------------------------------------------
module rc4_or_xor_stream_cipher_unit import rc4x_pkg::*; #(
   parameter int KEY_DEPTH   = 256,
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_in,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_result_byte,
   output logic        rsp_last_out,
   // configuration
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int LW  = $clog2(KEY_DEPTH + 1);
   localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int OB  = OFFSET_BITS;

   // sequencer states
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MOD  = 4'd1;
   localparam logic [3:0] S_XRD  = 4'd2;
   localparam logic [3:0] S_XOUT = 4'd3;
   localparam logic [3:0] S_FILL = 4'd4;
   localparam logic [3:0] S_K1   = 4'd5;
   localparam logic [3:0] S_K2   = 4'd6;
   localparam logic [3:0] S_K3   = 4'd7;
   localparam logic [3:0] S_K4   = 4'd8;
   localparam logic [3:0] S_P1   = 4'd9;
   localparam logic [3:0] S_P2   = 4'd10;
   localparam logic [3:0] S_P3   = 4'd11;
   localparam logic [3:0] S_P4   = 4'd12;
   localparam logic [3:0] S_P5   = 4'd13;
   localparam logic [3:0] S_P6   = 4'd14;

   // configuration registers
   logic          csr_mode_ff;
   logic [8:0]    csr_len_ff;
   logic [31:0]   csr_off_ff;

   // sequencer and message state
   logic [3:0]    state_ff, state_in;
   logic          msg_active_ff, msg_active_in;
   logic          mode_ff, mode_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] key_cnt_ff, key_cnt_in;
   logic [LW-1:0] key_pos_ff, key_pos_in;
   logic [LW-1:0] ksa_pos_ff, ksa_pos_in;
   byte_type      n_ff, n_in;
   byte_type      i_ff, i_in;
   byte_type      j_ff, j_in;
   byte_type      a_ff, a_in;
   byte_type      b_ff, b_in;
   logic [OB-1:0] skip_ff, skip_in;
   byte_type      data_ff, data_in;
   logic          last_ff, last_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   byte_type      rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_out_in;

   // memories
   byte_type      perm_mem [256];
   byte_type      perm_rd_ff;
   byte_type      perm_raddr, perm_waddr, perm_wdata;
   logic          perm_we;
   byte_type      key_mem [KEY_DEPTH];
   byte_type      key_rd_ff;
   logic [KAW-1:0] key_raddr, key_waddr;
   logic          key_we;

   // remainder unit
   logic           mod_start;
   mod_status_type mod_status;
   logic [LW-1:0]  mod_rem;

   logic [LW-1:0] eff_len;
   logic          req_fire;

   // key length clamped to 1..KEY_DEPTH
   always_comb begin
      if (csr_len_ff == 9'd0) begin
         eff_len = LW'(1);
      end else if (32'(csr_len_ff) > KEY_DEPTH) begin
         eff_len = LW'(KEY_DEPTH);
      end else begin
         eff_len = LW'(csr_len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mode_ff <= 1'b0;
         csr_len_ff  <= 9'd1;
         csr_off_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CIPHER_MODE:  csr_mode_ff <= csr_write_data[0];
            CSR_KEY_LENGTH:   csr_len_ff  <= csr_write_data[8:0];
            CSR_START_OFFSET: csr_off_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   rc4x_mod_unit #(
      .OB (OB),
      .LW (LW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (csr_off_ff[OB-1:0]),
      .divisor   (eff_len),
      .status    (mod_status),
      .remainder (mod_rem)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in        = state_ff;
      msg_active_in   = msg_active_ff;
      mode_in         = mode_ff;
      len_in          = len_ff;
      key_cnt_in      = key_cnt_ff;
      key_pos_in      = key_pos_ff;
      ksa_pos_in      = ksa_pos_ff;
      n_in            = n_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      skip_in         = skip_ff;
      data_in         = data_ff;
      last_in         = last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_byte_in     = rsp_byte_ff;
      rsp_last_out_in = rsp_last_ff;
      perm_raddr      = n_ff;
      perm_waddr      = n_ff;
      perm_wdata      = n_ff;
      perm_we         = 1'b0;
      key_raddr       = key_pos_ff[KAW-1:0];
      key_waddr       = key_cnt_ff[KAW-1:0];
      key_we          = 1'b0;
      mod_start       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_func) begin
                  // key word: append, extra bytes beyond the store dropped
                  if (32'(key_cnt_ff) < KEY_DEPTH) begin
                     key_we     = 1'b1;
                     key_cnt_in = key_cnt_ff + LW'(1);
                  end
                  if (req_last_in) begin
                     key_cnt_in = '0;
                  end
               end else begin
                  data_in = req_byte_value;
                  last_in = req_last_in;
                  if (!msg_active_ff) begin
                     msg_active_in = 1'b1;
                     mode_in       = csr_mode_ff;
                     len_in        = eff_len;
                     if (csr_mode_ff) begin
                        n_in     = '0;
                        skip_in  = csr_off_ff[OB-1:0];
                        state_in = S_FILL;
                     end else begin
                        mod_start = 1'b1;
                        state_in  = S_MOD;
                     end
                  end else if (mode_ff) begin
                     state_in = S_P1;
                  end else begin
                     state_in = S_XRD;
                  end
               end
            end
         end
         S_MOD: begin
            if (mod_status.done) begin
               key_pos_in = mod_rem;
               state_in   = S_XRD;
            end
         end
         S_XRD: begin
            // key store read issued here, wrap position for the next word
            if (({1'b0, key_pos_ff} + (LW+1)'(1)) >= {1'b0, len_ff}) begin
               key_pos_in = '0;
            end else begin
               key_pos_in = key_pos_ff + LW'(1);
            end
            state_in = S_XOUT;
         end
         S_XOUT: begin
            rsp_valid_in    = 1'b1;
            rsp_byte_in     = data_ff ^ key_rd_ff;
            rsp_last_out_in = last_ff;
            if (last_ff) begin
               msg_active_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         S_FILL: begin
            // identity permutation, one entry a cycle
            perm_we = 1'b1;
            n_in    = n_ff + 8'd1;
            if (n_ff == BYTE_LAST) begin
               j_in       = '0;
               ksa_pos_in = '0;
               state_in   = S_K1;
            end
         end
         S_K1: begin
            key_raddr = ksa_pos_ff[KAW-1:0];
            state_in  = S_K2;
         end
         S_K2: begin
            a_in       = perm_rd_ff;
            j_in       = 8'(j_ff + perm_rd_ff + key_rd_ff);
            perm_raddr = j_in;
            state_in   = S_K3;
         end
         S_K3: begin
            perm_we    = 1'b1;
            perm_wdata = perm_rd_ff;
            state_in   = S_K4;
         end
         S_K4: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = a_ff;
            if (({1'b0, ksa_pos_ff} + (LW+1)'(1)) >= {1'b0, len_ff}) begin
               ksa_pos_in = '0;
            end else begin
               ksa_pos_in = ksa_pos_ff + LW'(1);
            end
            n_in = n_ff + 8'd1;
            if (n_ff == BYTE_LAST) begin
               i_in     = '0;
               j_in     = '0;
               state_in = S_P1;
            end else begin
               state_in = S_K1;
            end
         end
         S_P1: begin
            i_in       = i_ff + 8'd1;
            perm_raddr = i_in;
            state_in   = S_P2;
         end
         S_P2: begin
            a_in       = perm_rd_ff;
            j_in       = j_ff + perm_rd_ff;
            perm_raddr = j_in;
            state_in   = S_P3;
         end
         S_P3: begin
            b_in       = perm_rd_ff;
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rd_ff;
            state_in   = S_P4;
         end
         S_P4: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = a_ff;
            // discarded keystream bytes loop back for another step
            if (skip_ff != '0) begin
               skip_in  = skip_ff - OB'(1);
               state_in = S_P1;
            end else begin
               state_in = S_P5;
            end
         end
         S_P5: begin
            perm_raddr = a_ff + b_ff;
            state_in   = S_P6;
         end
         S_P6: begin
            rsp_valid_in    = 1'b1;
            rsp_byte_in     = data_ff ^ perm_rd_ff;
            rsp_last_out_in = last_ff;
            if (last_ff) begin
               msg_active_in = 1'b0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // permutation memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_waddr] <= perm_wdata;
      end
      perm_rd_ff <= perm_mem[perm_raddr];
   end

   // key store
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= req_byte_value;
      end
      key_rd_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         msg_active_ff <= 1'b0;
         mode_ff       <= 1'b0;
         len_ff        <= LW'(1);
         key_cnt_ff    <= '0;
         key_pos_ff    <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         skip_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         msg_active_ff <= msg_active_in;
         mode_ff       <= mode_in;
         len_ff        <= len_in;
         key_cnt_ff    <= key_cnt_in;
         key_pos_ff    <= key_pos_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         skip_ff       <= skip_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ksa_pos_ff  <= ksa_pos_in;
      n_ff        <= n_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_byte_ff;
   assign rsp_last_out    = rsp_last_ff;

   // remainder unit only runs while the sequencer waits for it
   a_mod_busy: assert property (@(posedge clock) disable iff (reset)
      mod_status.busy |-> state_ff == S_MOD)
      else $error("remainder unit busy outside its state");

   // xor position search only for xor messages
   a_mod_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MOD |-> !mode_ff && msg_active_ff)
      else $error("remainder search in wrong mode");

   // a result is only formed inside an open message, over an empty output register
   a_out_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_XOUT || state_ff == S_P6) |-> msg_active_ff && !rsp_valid_ff)
      else $error("result formed outside a message or over a pending word");

   // key fill count never passes the store depth
   a_key_cnt: assert property (@(posedge clock) disable iff (reset)
      32'(key_cnt_ff) <= KEY_DEPTH)
      else $error("key count overflow");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the rc4 / xor stream cipher unit
// ----------------------------------------------------------------------------
// A queue of input words, filled phase by phase by the stimulus block, feeds
// a clocked driver. Every accepted word runs through a cycle-free model of the
// cipher that keeps its own key store, permutation and indexes. The result
// words it predicts are matched in order by a clocked monitor. Both sides idle
// in random bursts. Registers change only with the unit idle.
// ----------------------------------------------------------------------------
module tb;
   import rc4x_pkg::*;

   localparam int  LIMIT_CYCLES = 3000000;
   localparam int  SETTLE       = 60;     // > remainder pass of OFFSET_BITS
   localparam bit  FUNC_KEY     = 1'b0;
   localparam bit  FUNC_DATA    = 1'b1;
   localparam bit  MODE_XOR     = 1'b0;
   localparam bit  MODE_RC4     = 1'b1;

   typedef struct packed {
      logic     func;
      byte_type value;
      logic     last;
   } in_word_type;

   typedef struct packed {
      byte_type value;
      logic     last;
   } out_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [7:0]  req_byte_value = 8'd0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_result_byte;
   logic        rsp_last_out;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_CIPHER_MODE;
   logic [31:0] csr_write_data = 32'd0;

   rc4_or_xor_stream_cipher_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   in_word_type  pending_words[$];
   out_word_type expected_words[$];
   int           errors = 0;
   int           cycles = 0;
   bit           calm = 1'b0;   // no idling in the last part of the run

   // ---------------------------------------------------------------------
   // cipher model
   // ---------------------------------------------------------------------
   logic        cfg_mode = MODE_XOR;
   logic [8:0]  cfg_len  = 9'd1;
   logic [31:0] cfg_off  = 32'd0;

   byte_type    key_mem[256];
   byte_type    perm[256];
   byte_type    idx_i, idx_j;
   int          key_pos;
   int          load_count;
   bit          in_message;
   logic        msg_mode;
   int          msg_len;

   function automatic byte_type next_keystream();
      byte_type t;
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      t = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = t;
      return perm[byte_type'(perm[idx_i] + perm[idx_j])];
   endfunction

   task automatic schedule_key(int len, logic [31:0] skip);
      byte_type j;
      byte_type t;
      j = 8'd0;
      for (int n = 0; n < 256; n++) perm[n] = byte_type'(n);
      for (int n = 0; n < 256; n++) begin
         j = j + perm[n] + key_mem[n % len];
         t = perm[n];
         perm[n] = perm[j];
         perm[j] = t;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
      for (longint s = 0; s < skip; s++) void'(next_keystream());
   endtask

   task automatic cipher_predict(in_word_type w);
      byte_type ks;
      if (w.func == FUNC_KEY) begin
         if (load_count < 256) begin
            key_mem[load_count] = w.value;
            load_count++;
         end
         if (w.last) load_count = 0;
         return;
      end
      if (!in_message) begin
         in_message = 1'b1;
         msg_mode = cfg_mode;
         msg_len = (cfg_len == 0) ? 1 : (cfg_len > 256) ? 256 : int'(cfg_len);
         if (msg_mode == MODE_RC4) schedule_key(msg_len, cfg_off);
         else key_pos = int'(cfg_off % msg_len);
      end
      if (msg_mode == MODE_RC4) ks = next_keystream();
      else begin
         ks = key_mem[key_pos];
         key_pos++;
         if (key_pos >= msg_len) key_pos = 0;
      end
      if (w.last) in_message = 1'b0;
      expected_words.push_back('{value: w.value ^ ks, last: w.last});
   endtask

   // ---------------------------------------------------------------------
   // driver: one word from the queue at a time, valid held until taken
   // ---------------------------------------------------------------------
   in_word_type on_bus;
   int          send_gap = 0;

   always @(posedge clock) begin
      in_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) cipher_predict(on_bus);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               w = pending_words.pop_front();
               on_bus = w;
               req_func <= w.func;
               req_byte_value <= w.value;
               req_last_in <= w.last;
               req_valid <= 1'b1;
               // idle burst after this word
               if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: random stalls on ready, in-order compare
   // ---------------------------------------------------------------------
   int stall = 0;

   always @(posedge clock) begin
      out_word_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, actual %h last %b", $realtime,
                        rsp_result_byte, rsp_last_out);
               errors++;
            end else begin
               e = expected_words.pop_front();
               if (rsp_result_byte !== e.value) begin
                  $display("%0t: result_byte expected %h actual %h", $realtime, e.value,
                           rsp_result_byte);
                  errors++;
               end
               if (rsp_last_out !== e.last) begin
                  $display("%0t: last_out expected %b actual %b", $realtime, e.last,
                           rsp_last_out);
                  errors++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 14);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   // wait until every word is taken and every result is back, then let a
   // possible remainder pass run out
   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // writes all three registers on consecutive edges
   task automatic set_regs(logic mode, logic [8:0] len, logic [31:0] off);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CIPHER_MODE;
      csr_write_data <= {31'd0, mode};
      cfg_mode = mode;
      @(posedge clock);
      csr_index <= CSR_KEY_LENGTH;
      csr_write_data <= {23'd0, len};
      cfg_len = len;
      @(posedge clock);
      csr_index <= CSR_START_OFFSET;
      csr_write_data <= off;
      cfg_off = off;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_word(logic func, byte_type value, logic last);
      pending_words.push_back('{func: func, value: value, last: last});
   endtask

   task automatic push_key_load(int n, bit close);
      for (int k = 0; k < n; k++)
         push_word(FUNC_KEY, byte_type'($urandom), close && (k == n - 1));
   endtask

   // random traffic: messages with key words mixed in, some broken
   task automatic push_traffic(int budget);
      int n;
      while (budget > 0) begin
         case ($urandom_range(0, 9))
            0: begin
               n = $urandom_range(1, 8);
               push_key_load(n, $urandom_range(0, 1));
               budget -= n;
            end
            default: begin
               n = $urandom_range(1, 12);
               for (int k = 0; k < n; k++) begin
                  // key word in the middle of a message
                  if ($urandom_range(0, 19) == 0) push_word(FUNC_KEY, byte_type'($urandom), 1'b0);
                  // a message left open now and then
                  push_word(FUNC_DATA, byte_type'($urandom),
                            (k == n - 1) && ($urandom_range(0, 14) != 0));
               end
               budget -= n;
            end
         endcase
      end
   endtask

   initial begin
      logic        mode;
      logic [8:0]  len;
      logic [31:0] off;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // full key first so no entry is ever read unwritten; overflow drops two
      set_regs(MODE_XOR, 9'd256, 32'hFFFF_FFFF);
      push_key_load(258, 1'b1);
      push_word(FUNC_DATA, 8'h00, 1'b0);
      push_word(FUNC_DATA, 8'hFF, 1'b0);
      push_word(FUNC_DATA, 8'h5A, 1'b1);
      wait_idle();

      // key length zero acts as one
      set_regs(MODE_XOR, 9'd0, 32'd5);
      push_word(FUNC_DATA, 8'hFF, 1'b0);
      push_word(FUNC_DATA, 8'h00, 1'b1);
      wait_idle();

      // oversized key length, rc4 without discard, key word inside message
      set_regs(MODE_RC4, 9'h1FF, 32'd0);
      push_word(FUNC_DATA, 8'h00, 1'b0);
      push_word(FUNC_KEY, 8'hA5, 1'b1);
      push_word(FUNC_DATA, 8'hFF, 1'b0);
      // settings change while the message is open: next message only
      wait_idle();
      set_regs(MODE_XOR, 9'd3, 32'd7);
      push_word(FUNC_DATA, 8'h81, 1'b1);
      push_word(FUNC_DATA, 8'h7E, 1'b1);
      wait_idle();

      // rc4, one-byte key, short discard
      set_regs(MODE_RC4, 9'd1, 32'd3);
      push_word(FUNC_DATA, 8'h3C, 1'b0);
      push_word(FUNC_DATA, 8'hC3, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 12; phase++) begin
         if (phase >= 10) calm = 1'b1;
         mode = $urandom_range(0, 1);
         case ($urandom_range(0, 5))
            0: len = 9'd1;
            1: len = 9'd256;
            2: len = 9'($urandom_range(257, 511));
            default: len = 9'($urandom_range(1, 256));
         endcase
         // rc4 discard runs a keystream step for every byte, keep it short mostly
         if (mode == MODE_RC4)
            off = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400) : $urandom_range(0, 40);
         else
            off = $urandom;
         set_regs(mode, len, off);
         push_traffic(52);
         wait_idle();   // sender holds off until all results are back
      end

      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
